### hw/rtl/leb_pkg.sv
// shared types and constants for the line edit buffer
package leb_pkg;

    // default line storage in bytes, one entry stays unused so length fits the index
    localparam int LINE_BYTES_DEF = 64;

    localparam int OP_W     = 3;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;

    // edit operation codes on the op field
    typedef enum logic [OP_W-1:0] {
        OP_CHAR    = 3'd0,
        OP_LEFT    = 3'd1,
        OP_RIGHT   = 3'd2,
        OP_DEL_FWD = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_CONSUMED   = 2'd0,
        ST_DISCARDED  = 2'd1,
        ST_COMPLETED  = 2'd2,
        ST_TERMINATED = 2'd3
    } status_t;

    // last newline character seen
    typedef enum logic [1:0] {
        NL_NONE = 2'd0,
        NL_CR   = 2'd1,
        NL_LF   = 2'd2
    } nl_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SH_RD,
        S_SH_WR,
        S_INS,
        S_EM_RD,
        S_EM_LD,
        S_OUT
    } state_t;

    // control characters
    localparam logic [CHAR_W-1:0] CH_ETX = 8'h03;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

endpackage

### hw/rtl/leb_ram.sv
// generic single write port, single read port ram with registered read
module leb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/line_edit_buffer.sv
// top level of the console line editor
// Console line editor: each input transaction is a received character or an edit event
// (cursor left, cursor right, delete forward, clear line), and each one yields one or more
// result transactions. The line lives in a single ram with one write and one registered read
// port, and all data movement goes through that port under a small sequencer, one input at a
// time. Edit events and ignored characters yield a single result. Deleting a character moves the
// tail of the line left one entry at a time, each entry read and then written back; inserting
// one pushes the tail right the same way and then writes the character. Completing or
// terminating a line gives one result per character, each read from the ram before it is
// offered, or a single result for an empty line; a low out_ready holds each result. in_ready is
// high only while the sequencer is idle. The ram needs no clearing after reset: only entries
// below the line length are ever read.
module line_edit_buffer #(
    parameter int LINE_BYTES = leb_pkg::LINE_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [leb_pkg::OP_W-1:0]      op,
    input  logic [leb_pkg::CHAR_W-1:0]    ch,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [leb_pkg::STATUS_W-1:0]  status,
    output logic                          has_char,
    output logic [leb_pkg::CHAR_W-1:0]    line_char,
    output logic                          last
);

    import leb_pkg::*;

    localparam int AW = $clog2(LINE_BYTES);
    localparam logic [AW-1:0] MAX_LEN = AW'(LINE_BYTES - 1);

    state_t              state_reg, state_next;
    logic [AW-1:0]       cursor_reg, cursor_next;
    logic [AW-1:0]       len_reg, len_next;
    nl_t                 nl_reg, nl_next;
    logic [AW-1:0]       dst_reg, dst_next;
    logic [AW-1:0]       lim_reg, lim_next;
    logic                dir_left_reg, dir_left_next;
    logic [CHAR_W-1:0]   ch_reg, ch_next;
    status_t             status_reg, status_next;
    logic                has_char_reg, has_char_next;
    logic [CHAR_W-1:0]   line_char_reg, line_char_next;
    logic                last_reg, last_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [CHAR_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [CHAR_W-1:0]   ram_rdata;

    // line storage
    leb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_BYTES)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cursor_reg <= '0;
            len_reg    <= '0;
            nl_reg     <= NL_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            len_reg    <= len_next;
            nl_reg     <= nl_next;
        end
    end

    // payload and loop registers
    always_ff @(posedge clk)
    begin
        dst_reg       <= dst_next;
        lim_reg       <= lim_next;
        dir_left_reg  <= dir_left_next;
        ch_reg        <= ch_next;
        status_reg    <= status_next;
        has_char_reg  <= has_char_next;
        line_char_reg <= line_char_next;
        last_reg      <= last_next;
    end

    // sequencer next state and datapath control
    always_comb
    begin
        logic    go_single;
        logic    go_emit;
        status_t res_status;
        nl_t     nl_code;

        go_single  = 1'b0;
        go_emit    = 1'b0;
        res_status = ST_CONSUMED;
        nl_code    = NL_NONE;

        state_next     = state_reg;
        cursor_next    = cursor_reg;
        len_next       = len_reg;
        nl_next        = nl_reg;
        dst_next       = dst_reg;
        lim_next       = lim_reg;
        dir_left_next  = dir_left_reg;
        ch_next        = ch_reg;
        status_next    = status_reg;
        has_char_next  = has_char_reg;
        line_char_next = line_char_reg;
        last_next      = last_reg;

        ram_we    = 1'b0;
        ram_waddr = dst_reg;
        ram_wdata = ram_rdata;
        ram_raddr = dst_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op)
                        OP_CHAR:
                        begin
                            if (ch == CH_ETX)
                            begin
                                go_emit    = 1'b1;
                                res_status = ST_TERMINATED;
                            end
                            else if (ch == CH_CR || ch == CH_LF)
                            begin
                                nl_code = (ch == CH_CR) ? NL_CR : NL_LF;
                                nl_next = nl_code;
                                if (nl_reg == NL_NONE || nl_reg == nl_code)
                                begin
                                    go_emit    = 1'b1;
                                    res_status = ST_COMPLETED;
                                end
                                else
                                begin
                                    // second half of a cr/lf pair is swallowed
                                    go_single  = 1'b1;
                                    res_status = ST_CONSUMED;
                                end
                            end
                            else if (ch == CH_BS || ch == CH_DEL)
                            begin
                                nl_next = NL_NONE;
                                if (cursor_reg == '0)
                                begin
                                    go_single  = 1'b1;
                                    res_status = ST_DISCARDED;
                                end
                                else
                                begin
                                    // pull the tail left over the char before the cursor
                                    dst_next      = cursor_reg - 1'b1;
                                    lim_next      = len_reg - 1'b1;
                                    dir_left_next = 1'b1;
                                    cursor_next   = cursor_reg - 1'b1;
                                    len_next      = len_reg - 1'b1;
                                    status_next   = ST_CONSUMED;
                                    state_next    = S_SH_RD;
                                end
                            end
                            else
                            begin
                                nl_next = NL_NONE;
                                if (len_reg >= MAX_LEN)
                                begin
                                    go_single  = 1'b1;
                                    res_status = ST_DISCARDED;
                                end
                                else
                                begin
                                    // push the tail right, then drop the char in
                                    dst_next      = len_reg;
                                    lim_next      = cursor_reg;
                                    dir_left_next = 1'b0;
                                    ch_next       = ch;
                                    cursor_next   = cursor_reg + 1'b1;
                                    len_next      = len_reg + 1'b1;
                                    status_next   = ST_CONSUMED;
                                    state_next    = S_SH_RD;
                                end
                            end
                        end
                        OP_LEFT:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg - 1'b1;
                            end
                            go_single  = 1'b1;
                            res_status = ST_CONSUMED;
                        end
                        OP_RIGHT:
                        begin
                            if (cursor_reg < len_reg)
                            begin
                                cursor_next = cursor_reg + 1'b1;
                            end
                            go_single  = 1'b1;
                            res_status = ST_CONSUMED;
                        end
                        OP_DEL_FWD:
                        begin
                            if (cursor_reg >= len_reg)
                            begin
                                go_single  = 1'b1;
                                res_status = ST_DISCARDED;
                            end
                            else
                            begin
                                dst_next      = cursor_reg;
                                lim_next      = len_reg - 1'b1;
                                dir_left_next = 1'b1;
                                len_next      = len_reg - 1'b1;
                                status_next   = ST_CONSUMED;
                                state_next    = S_SH_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cursor_next = '0;
                            len_next    = '0;
                            go_single   = 1'b1;
                            res_status  = ST_CONSUMED;
                        end
                        default:
                        begin
                            go_single  = 1'b1;
                            res_status = ST_DISCARDED;
                        end
                    endcase

                    // an empty line still gives one result
                    if (go_emit)
                    begin
                        status_next = res_status;
                        if (len_reg == '0)
                        begin
                            go_single = 1'b1;
                        end
                        else
                        begin
                            dst_next   = '0;
                            state_next = S_EM_RD;
                        end
                    end

                    if (go_single)
                    begin
                        status_next    = res_status;
                        has_char_next  = 1'b0;
                        line_char_next = '0;
                        last_next      = 1'b1;
                        state_next     = S_OUT;
                    end
                end
            end
            S_SH_RD:
            begin
                if (dst_reg == lim_reg)
                begin
                    if (dir_left_reg)
                    begin
                        has_char_next  = 1'b0;
                        line_char_next = '0;
                        last_next      = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        state_next = S_INS;
                    end
                end
                else
                begin
                    ram_raddr  = dir_left_reg ? dst_reg + 1'b1 : dst_reg - 1'b1;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = dst_reg;
                ram_wdata  = ram_rdata;
                dst_next   = dir_left_reg ? dst_reg + 1'b1 : dst_reg - 1'b1;
                state_next = S_SH_RD;
            end
            S_INS:
            begin
                ram_we         = 1'b1;
                ram_waddr      = lim_reg;
                ram_wdata      = ch_reg;
                has_char_next  = 1'b0;
                line_char_next = '0;
                last_next      = 1'b1;
                state_next     = S_OUT;
            end
            S_EM_RD:
            begin
                ram_raddr  = dst_reg;
                state_next = S_EM_LD;
            end
            S_EM_LD:
            begin
                has_char_next  = 1'b1;
                line_char_next = ram_rdata;
                last_next      = (({1'b0, dst_reg} + 1'b1) == {1'b0, len_reg});
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (has_char_reg && !last_reg)
                    begin
                        dst_next   = dst_reg + 1'b1;
                        state_next = S_EM_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // handshake and result ports
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status    = status_reg;
    assign has_char  = has_char_reg;
    assign line_char = line_char_reg;
    assign last      = last_reg;

endmodule
